// ===== src/sda_pkg.sv =====
// Shared types and constants for the signed to decimal ASCII converter.
// Used by sda_dabble and signed_to_decimal_ascii_top; no dependencies.
`timescale 1ns / 1ps

package sda_pkg;

    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [3:0] DAB_LIMIT  = 4'd5;
    localparam logic [3:0] DAB_ADJUST = 4'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SIGN,
        ST_DIGITS
    } sda_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic shift;
    } sda_ctrl_t;

endpackage

// ===== src/sda_dabble.sv =====
// Shift-and-add-3 binary to BCD unit with a digit output shifter.
// Depends on sda_pkg for the control struct and the correction constants.
`timescale 1ns / 1ps

module sda_dabble
    import sda_pkg::*;
#(
    parameter int VALUE_WIDTH = 64,
    parameter int NUM_DIGITS  = 20
)
(
    input  logic                   clk,
    input  sda_ctrl_t              ctrl,
    input  logic [VALUE_WIDTH-1:0] magnitude,
    output logic [3:0]             top_digit
);

    localparam int BCD_WIDTH = 4 * NUM_DIGITS;

    logic [VALUE_WIDTH-1:0] bin_reg;
    logic [VALUE_WIDTH-1:0] bin_next;
    logic [BCD_WIDTH-1:0]   bcd_reg;
    logic [BCD_WIDTH-1:0]   bcd_next;
    logic [BCD_WIDTH-1:0]   bcd_adj;

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= DAB_LIMIT)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + DAB_ADJUST;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        if (ctrl.load)
        begin
            bin_next = magnitude;
            bcd_next = '0;
        end
        else if (ctrl.step)
        begin
            bin_next = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
            bcd_next = {bcd_adj[BCD_WIDTH-2:0], bin_reg[VALUE_WIDTH-1]};
        end
        else if (ctrl.shift)
        begin
            bcd_next = {bcd_reg[BCD_WIDTH-5:0], 4'd0};
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign top_digit = bcd_reg[BCD_WIDTH-1 -: 4];

endmodule

// ===== src/signed_to_decimal_ascii_top.sv =====
// Sequence: ST_CONVERT runs the bit-serial shift-and-add-3 loop over all VALUE_WIDTH bits, then
// ST_DIGITS shifts out the NUM_DIGITS BCD digits, skipping leading zeros and sending the rest.
// A negative item first passes through ST_SIGN, which sends the minus sign.
// A new item is accepted only in idle (busy low), after the last character of the previous one.
// Reset: rst_n clears the sequencer to idle; the receiver cannot stall characters.
// Depends on sda_pkg and sda_dabble.
`timescale 1ns / 1ps

module signed_to_decimal_ascii_top
    import sda_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] value,
    output logic        busy,
    output logic        valid,
    output logic [7:0]  char_code,
    output logic        last
);

    localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BIT_CW     = $clog2(VALUE_WIDTH);
    localparam int DIG_CW     = $clog2(NUM_DIGITS);

    sda_state_t state_reg;
    sda_state_t state_next;
    logic [BIT_CW-1:0] bit_cnt_reg;
    logic [BIT_CW-1:0] bit_cnt_next;
    logic [DIG_CW-1:0] dig_cnt_reg;
    logic [DIG_CW-1:0] dig_cnt_next;
    logic neg_reg;
    logic neg_next;
    logic started_reg;
    logic started_next;

    logic [VALUE_WIDTH-1:0] raw;
    logic [VALUE_WIDTH-1:0] magnitude;
    logic [3:0]             top_digit;
    sda_ctrl_t              ctrl;

    assign raw       = value[VALUE_WIDTH-1:0];
    assign magnitude = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;

    sda_dabble #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NUM_DIGITS  (NUM_DIGITS)
    ) u_dabble (
        .clk       (clk),
        .ctrl      (ctrl),
        .magnitude (magnitude),
        .top_digit (top_digit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
            neg_reg     <= 1'b0;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
            neg_reg     <= neg_next;
            started_reg <= started_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        neg_next     = neg_reg;
        started_next = started_reg;
        ctrl         = '0;
        busy         = 1'b1;
        valid        = 1'b0;
        char_code    = CH_ZERO;
        last         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctrl.load    = 1'b1;
                    neg_next     = raw[VALUE_WIDTH-1];
                    bit_cnt_next = BIT_CW'(VALUE_WIDTH - 1);
                    state_next   = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                ctrl.step = 1'b1;
                if (bit_cnt_reg == '0)
                begin
                    dig_cnt_next = DIG_CW'(NUM_DIGITS - 1);
                    started_next = 1'b0;
                    state_next   = neg_reg ? ST_SIGN : ST_DIGITS;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                end
            end
            ST_SIGN:
            begin
                valid      = 1'b1;
                char_code  = CH_MINUS;
                state_next = ST_DIGITS;
            end
            ST_DIGITS:
            begin
                ctrl.shift = 1'b1;
                if (!started_reg && top_digit == 4'd0 && dig_cnt_reg != '0)
                begin
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                end
                else
                begin
                    valid        = 1'b1;
                    char_code    = CH_ZERO + {4'd0, top_digit};
                    last         = (dig_cnt_reg == '0);
                    started_next = 1'b1;
                    if (dig_cnt_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        dig_cnt_next = dig_cnt_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
